FILE: design/assert_macros.svh
// Assertion macros shared by the relief shader RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Immediate-implication check, disabled while reset is asserted (active low).
`define HMRS_ASSERT(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Next-cycle implication check, disabled while reset is asserted (active low).
`define HMRS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/hmrs_pkg.sv
// Package for the relief shader: widths, register codes, stage struct.
// Used by every module of the block; no dependencies.
`default_nettype none
package hmrs_pkg;

  localparam int LINE_BUF_DEPTH = 4096;     // default max pixels per row
  localparam int LINE_WIDTH_W   = 13;
  localparam int COLOR_W        = 24;
  localparam int HEIGHT_W       = 16;
  localparam int LB_DATA_W      = HEIGHT_W + 1;  // {valid, height}
  localparam int CFG_INDEX_W    = 1;
  localparam int CFG_DATA_W     = LINE_WIDTH_W;

  localparam logic [LINE_WIDTH_W-1:0] LINE_WIDTH_RESET = 13'd4096;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_LINE_WIDTH     = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SHADING_ENABLE = 1'd1;

  localparam int          SHADE_GAIN  = 12;
  localparam logic [7:0]  CHANNEL_MAX = 8'd255;
  localparam int          D_W         = 22;      // 12 * (2h - hl - hu)
  localparam logic signed [D_W-1:0] D_CLAMP = 22'sd36;

  // pixel held between the line-buffer read and the shading stage
  typedef struct packed {
    logic [COLOR_W-1:0]         color;
    logic signed [HEIGHT_W-1:0] height;
    logic signed [HEIGHT_W-1:0] left_height;
    logic                       height_valid;
    logic                       left_ok;
    logic                       upper_ok;    // not in first row
  } hmrs_pix_t;

endpackage
`default_nettype wire

FILE: design/hmrs_line_buf.sv
// Line buffer: heights and valid bits of the previous row.
// Single address, read-first, registered read data. Uses hmrs_pkg.
`default_nettype none
module hmrs_line_buf
  import hmrs_pkg::*;
#(
  parameter int DEPTH = LINE_BUF_DEPTH,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic                 clk,
  input  wire logic                 en,
  input  wire logic [AW-1:0]        addr,
  input  wire logic [LB_DATA_W-1:0] wdata,
  output logic      [LB_DATA_W-1:0] rdata
);

  logic [LB_DATA_W-1:0] mem [DEPTH];
  logic [LB_DATA_W-1:0] rdata_r;

  // old contents come out while the new pixel goes in
  always_ff @(posedge clk) begin
    if (en) begin
      rdata_r   <= mem[addr];
      mem[addr] <= wdata;
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

FILE: design/hmrs_shade_stage.sv
// Shading arithmetic and output register of the relief shader.
// Uses hmrs_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module hmrs_shade_stage
  import hmrs_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 shading_enable,
  input  wire logic                 pix_valid,
  input  wire hmrs_pix_t            pix,
  input  wire logic [LB_DATA_W-1:0] upper,
  output logic                      pix_ready,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [COLOR_W-1:0]        out_shaded_color
);

  logic                       out_valid_r, out_valid_nxt;
  logic [COLOR_W-1:0]         color_r, color_nxt;
  logic signed [HEIGHT_W-1:0] upper_height;
  logic                       upper_valid;
  logic signed [D_W-1:0]      diff, d_raw, d_clamped;
  logic                       apply;
  logic                       take;

  assign upper_height = upper[HEIGHT_W-1:0];
  assign upper_valid  = upper[HEIGHT_W];

  assign pix_ready = !out_valid_r || out_ready;
  assign take      = pix_valid && pix_ready;

  function automatic logic [7:0] sat_add(input logic [7:0] ch,
                                         input logic signed [D_W-1:0] d);
    logic signed [D_W:0] s;
    s = $signed({{(D_W-7){1'b0}}, ch}) + (D_W+1)'(d);
    if (s < 0)                                       return 8'd0;
    else if (s > $signed({{(D_W-7){1'b0}}, CHANNEL_MAX})) return CHANNEL_MAX;
    else                                             return s[7:0];
  endfunction

  always_comb begin
    diff = D_W'(pix.height) + D_W'(pix.height)
         - D_W'(pix.left_height) - D_W'(upper_height);
    // times 12 as two shifts
    d_raw     = (diff <<< 3) + (diff <<< 2);
    d_clamped = (d_raw > D_CLAMP) ? D_CLAMP : d_raw;
    apply = shading_enable && pix.height_valid && pix.left_ok
         && pix.upper_ok && upper_valid;
    color_nxt = color_r;
    if (take) begin
      if (apply) begin
        color_nxt = {sat_add(pix.color[23:16], d_clamped),
                     sat_add(pix.color[15:8],  d_clamped),
                     sat_add(pix.color[7:0],   d_clamped)};
      end else begin
        color_nxt = pix.color;
      end
    end
    out_valid_nxt = take ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    color_r <= color_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_shaded_color = color_r;

  `HMRS_ASSERT_NEXT(a_pass_through, clk, rst_n, take && !shading_enable, out_shaded_color == $past(pix.color), "color changed with shading disabled")
  `HMRS_ASSERT_NEXT(a_take_valid, clk, rst_n, take, out_valid, "taken pixel produced no result")

endmodule
`default_nettype wire

FILE: design/height_map_relief_shader.sv
// Relief shader top level: config registers, column/row tracking, line
// buffer and shading stage. Uses hmrs_pkg, hmrs_line_buf, hmrs_shade_stage.
//
// Usage:
//   Input channel (in_*): one map pixel per request in raster order, with
//   color, signed height, height-valid flag and frame_start on the first
//   pixel of a map. Output channel (out_*): one shaded color per request,
//   in input order. Both use valid/ready.
//   Config port (cfg_*): index 0 = line_width, index 1 = shading_enable,
//   written whenever cfg_we is high; write only while the block is idle.
//   Path: an accepted request goes through the stage register, then the output register.
//   Throughput: one pixel per clock while out_ready stays high; the line buffer is read and written at
//   the same column on the accepting edge (read-first), so back-to-back
//   pixels, even with a one-pixel row, never need forwarding.
//   Stalls: the output register holds a result while out_ready is low; the
//   stage in front still takes one more request, then in_ready drops.
//   Reset: synchronous, active low; clears pipeline valids, column, left
//   neighbor and sets first row; line_width = 4096, shading on. The line
//   buffer is not cleared: the first row ignores what it reads.
`default_nettype none
`include "assert_macros.svh"
module height_map_relief_shader
  import hmrs_pkg::*;
#(
  parameter int MAX_LINE_WIDTH = LINE_BUF_DEPTH
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  // config
  input  wire logic                       cfg_we,
  input  wire logic [CFG_INDEX_W-1:0]     cfg_index,
  input  wire logic [CFG_DATA_W-1:0]      cfg_wdata,
  // pixel input
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [COLOR_W-1:0]         in_pixel_color,
  input  wire logic signed [HEIGHT_W-1:0] in_terrain_height,
  input  wire logic                       in_height_valid,
  input  wire logic                       in_frame_start,
  // shaded output
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [COLOR_W-1:0]              out_shaded_color
);

  localparam int AW = $clog2(MAX_LINE_WIDTH);
  localparam int WW = (AW + 1 > LINE_WIDTH_W) ? AW + 1 : LINE_WIDTH_W;

  // config registers
  logic [LINE_WIDTH_W-1:0] line_width_r;
  logic                    shading_enable_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_width_r     <= LINE_WIDTH_RESET;
      shading_enable_r <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LINE_WIDTH:     line_width_r     <= cfg_wdata;
        REG_SHADING_ENABLE: shading_enable_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // effective width: 0 acts as 1, clamp at buffer depth
  logic [WW-1:0] lw_ext, eff_ext;
  logic [AW:0]   eff_width;

  always_comb begin
    lw_ext = WW'(line_width_r);
    if (lw_ext == '0)                       eff_ext = WW'(1);
    else if (lw_ext > WW'(MAX_LINE_WIDTH))  eff_ext = WW'(MAX_LINE_WIDTH);
    else                                    eff_ext = lw_ext;
    eff_width = eff_ext[AW:0];
  end

  // raster position and left neighbor
  logic [AW-1:0]              col_r, col_nxt, col_cur;
  logic                       first_row_r, first_row_nxt, first_row_cur;
  logic                       left_valid_r, left_valid_nxt;
  logic signed [HEIGHT_W-1:0] left_height_r, left_height_nxt;
  logic [AW:0]                col_inc;
  logic                       wrap;
  logic                       accept;

  // stage between line-buffer read and shading
  logic       s1_valid_r, s1_valid_nxt;
  hmrs_pix_t  s1_r, s1_nxt;
  logic       s1_ready;
  logic [LB_DATA_W-1:0] upper_q;

  assign in_ready = !s1_valid_r || s1_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    col_cur       = in_frame_start ? '0 : col_r;
    first_row_cur = in_frame_start || first_row_r;
    col_inc       = {1'b0, col_cur} + (AW+1)'(1);
    wrap          = col_inc >= eff_width;

    col_nxt         = col_r;
    first_row_nxt   = first_row_r;
    left_valid_nxt  = left_valid_r;
    left_height_nxt = left_height_r;
    s1_nxt          = s1_r;
    if (accept) begin
      s1_nxt.color        = in_pixel_color;
      s1_nxt.height       = in_terrain_height;
      s1_nxt.left_height  = left_height_r;
      s1_nxt.height_valid = in_height_valid;
      s1_nxt.left_ok      = (col_cur != '0) && !in_frame_start && left_valid_r;
      s1_nxt.upper_ok     = !first_row_cur;

      left_height_nxt = in_terrain_height;
      if (wrap) begin
        col_nxt        = '0;
        first_row_nxt  = 1'b0;
        left_valid_nxt = 1'b0;
      end else begin
        col_nxt        = col_inc[AW-1:0];
        first_row_nxt  = first_row_cur;
        left_valid_nxt = in_height_valid;
      end
    end
    s1_valid_nxt = accept ? 1'b1 : (s1_ready ? 1'b0 : s1_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r        <= '0;
      first_row_r  <= 1'b1;
      left_valid_r <= 1'b0;
      left_height_r <= '0;
      s1_valid_r   <= 1'b0;
    end else begin
      col_r        <= col_nxt;
      first_row_r  <= first_row_nxt;
      left_valid_r <= left_valid_nxt;
      left_height_r <= left_height_nxt;
      s1_valid_r   <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_r <= s1_nxt;
  end

  hmrs_line_buf #(
    .DEPTH (MAX_LINE_WIDTH),
    .AW    (AW)
  ) u_line_buf (
    .clk   (clk),
    .en    (accept),
    .addr  (col_cur),
    .wdata ({in_height_valid, in_terrain_height}),
    .rdata (upper_q)
  );

  hmrs_shade_stage u_shade (
    .clk              (clk),
    .rst_n            (rst_n),
    .shading_enable   (shading_enable_r),
    .pix_valid        (s1_valid_r),
    .pix              (s1_r),
    .upper            (upper_q),
    .pix_ready        (s1_ready),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_shaded_color (out_shaded_color)
  );

  `HMRS_ASSERT_NEXT(a_col_step, clk, rst_n, accept && !in_frame_start && !wrap, col_r == $past(col_r) + 1'b1, "column did not advance")
  `HMRS_ASSERT(a_row_end, clk, rst_n, $fell(first_row_r) |-> $past(accept && wrap), "first row ended off a row boundary")

endmodule
`default_nettype wire

FILE: tb/height_map_relief_shader_test.sv
// Self-checking bench for height_map_relief_shader: raster pixel requests with
// random pacing, results checked against a predictor of the relief shading.
// Depends on hmrs_pkg and the height_map_relief_shader RTL only.
module height_map_relief_shader_test;
  import hmrs_pkg::*;

  localparam int MAX_ROW      = LINE_BUF_DEPTH;  // line buffer depth of the DUT
  localparam int RELIEF_GAIN  = 12;
  localparam int RELIEF_CLAMP = 36;              // upper clamp on the shade offset
  localparam int STALL_LIMIT  = 2000;            // cycles with no request moving

  // one pixel request as it goes on the input channel
  typedef struct packed {
    logic [COLOR_W-1:0]         color;
    logic signed [HEIGHT_W-1:0] height;
    logic                       hv;
    logic                       fs;
  } pixel_req_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                       cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0]     cfg_index = REG_LINE_WIDTH;
  logic [CFG_DATA_W-1:0]      cfg_wdata = '0;

  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic [COLOR_W-1:0]         in_pixel_color = '0;
  logic signed [HEIGHT_W-1:0] in_terrain_height = '0;
  logic                       in_height_valid = 1'b0;
  logic                       in_frame_start = 1'b0;

  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic [COLOR_W-1:0]         out_shaded_color;

  height_map_relief_shader u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_pixel_color   (in_pixel_color),
    .in_terrain_height(in_terrain_height),
    .in_height_valid  (in_height_valid),
    .in_frame_start   (in_frame_start),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_shaded_color (out_shaded_color)
  );

  always #2 clk = ~clk;

  // Stimulus and expectation stores
  pixel_req_t          pending_pixels[$];
  logic [COLOR_W-1:0]  shaded_expect[$];

  bit in_pace  = 1'b1;   // 0: input side sends back to back
  bit out_pace = 1'b1;   // 0: output side never stalls
  bit in_taken = 1'b0;   // request accepted at the last rising edge
  bit run_failed = 1'b0;
  int in_gap = 0;
  int out_hold = 0;
  int idle_cycles = 0;

  // Predictor state: row above, left neighbor, raster position, registers
  logic signed [HEIGHT_W-1:0] row_above_h[MAX_ROW];
  logic                       row_above_v[MAX_ROW];
  logic signed [HEIGHT_W-1:0] left_h;
  logic                       left_v;
  int                         col_pos;
  logic                       in_first_row;
  logic [CFG_DATA_W-1:0]      line_width_reg;
  logic                       shading_on;

  // Gap length: mostly none, some short, a few long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Channel values biased toward the saturation points.
  function automatic logic [7:0] pick_channel();
    case ($urandom_range(0, 5))
      0: return 8'h00;
      1: return 8'hff;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] clip8(input int c);
    if (c > 255) return 8'hff;
    if (c < 0) return 8'h00;
    return 8'(c);
  endfunction

  // Shade one pixel and advance the raster state. Returns the expected color.
  function automatic logic [COLOR_W-1:0] shade_pixel(input pixel_req_t px);
    int row_len;
    int c;
    int d;
    logic left_ok;
    logic up_ok;
    logic [COLOR_W-1:0] result;
    // width 0 acts as 1, anything past the buffer depth as the depth
    if (line_width_reg == 0) row_len = 1;
    else if (line_width_reg > MAX_ROW) row_len = MAX_ROW;
    else row_len = int'(line_width_reg);
    if (px.fs) begin
      col_pos = 0;
      in_first_row = 1'b1;
      left_v = 1'b0;
    end
    c = col_pos % MAX_ROW;
    left_ok = (c != 0) && left_v;
    up_ok = !in_first_row && row_above_v[c];
    result = px.color;
    if (shading_on && px.hv && left_ok && up_ok) begin
      d = RELIEF_GAIN * (2 * int'(px.height) - int'(left_h) - int'(row_above_h[c]));
      if (d > RELIEF_CLAMP) d = RELIEF_CLAMP;   // no lower clamp; channels floor at 0
      result = {clip8(int'(px.color[23:16]) + d),
                clip8(int'(px.color[15:8]) + d),
                clip8(int'(px.color[7:0]) + d)};
    end
    row_above_h[c] = px.height;
    row_above_v[c] = px.hv;
    left_h = px.height;
    left_v = px.hv;
    // a column at or past a shrunken width still ends the row here
    c++;
    if (c >= row_len) begin
      c = 0;
      in_first_row = 1'b0;
      left_v = 1'b0;
    end
    col_pos = c;
    return result;
  endfunction

  // Input driver: new request at the falling edge once the previous one is gone.
  always @(negedge clk) begin : feed_pixels
    pixel_req_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (in_gap > 0 || pending_pixels.size() == 0) begin
        in_valid <= 1'b0;
        if (in_gap > 0) in_gap--;
      end else begin
        nxt = pending_pixels.pop_front();
        in_pixel_color    <= nxt.color;
        in_terrain_height <= nxt.height;
        in_height_valid   <= nxt.hv;
        in_frame_start    <= nxt.fs;
        in_valid          <= 1'b1;
        in_gap = in_pace ? pick_gap() : 0;
      end
    end
  end

  // Output back-pressure.
  always @(negedge clk) begin
    if (!out_pace) begin
      out_ready <= 1'b1;
      out_hold = 0;
    end else if (out_hold > 0) begin
      out_ready <= 1'b0;
      out_hold--;
    end else begin
      out_ready <= 1'b1;
      if ($urandom_range(0, 3) == 0) out_hold = pick_gap();
    end
  end

  // Monitor: register writes, predictions on input requests, checks on
  // result requests, and the no-progress watchdog.
  always @(posedge clk) begin : observe
    logic [COLOR_W-1:0] want;
    if (!rst_n) begin
      in_taken <= 1'b0;
      idle_cycles = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_LINE_WIDTH:     line_width_reg = cfg_wdata;
          REG_SHADING_ENABLE: shading_on = cfg_wdata[0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (shaded_expect.size() == 0) begin
          $error("shaded_color: expected nothing, actual %h", out_shaded_color);
          run_failed = 1'b1;
        end else begin
          want = shaded_expect.pop_front();
          if (out_shaded_color !== want) begin
            $error("shaded_color: expected %h, actual %h", want, out_shaded_color);
            run_failed = 1'b1;
          end
        end
      end
      if (in_valid && in_ready)
        shaded_expect.insert(shaded_expect.size(),
                             shade_pixel({in_pixel_color, in_terrain_height,
                                          in_height_valid, in_frame_start}));
      in_taken <= in_valid && in_ready;
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // Wait for every request to drain out of the block; returns at a falling edge.
  task automatic drain();
    while (pending_pixels.size() != 0 || in_valid || shaded_expect.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
  endtask

  // Both registers, back to back; called at a falling edge with the block idle.
  task automatic program_shader(input int width, input bit enable);
    cfg_we    <= 1'b1;
    cfg_index <= REG_LINE_WIDTH;
    cfg_wdata <= CFG_DATA_W'(width);
    @(negedge clk);
    cfg_index <= REG_SHADING_ENABLE;
    cfg_wdata <= CFG_DATA_W'(enable);
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic push_px(input logic [COLOR_W-1:0] color, input int h,
                         input bit hv, input bit fs);
    pixel_req_t px;
    px.color  = color;
    px.height = 16'(h);
    px.hv     = hv;
    px.fs     = fs;
    pending_pixels.insert(pending_pixels.size(), px);
  endtask

  // Smooth terrain: maps of a few whole rows (sometimes a partial one) around a
  // random base height, so shade offsets land near the clamp and the floor.
  // Stray heights, invalid heights and stray frame starts are the noise.
  task automatic queue_terrain(input int n_items, input int row_len,
                               input bit open_with_start);
    pixel_req_t px;
    logic signed [HEIGHT_W-1:0] base;
    int frame_left;
    int k;
    base = 16'($urandom);
    frame_left = open_with_start ? 0 : row_len * 2;
    for (k = 0; k < n_items; k++) begin
      px.fs = 1'b0;
      if (frame_left == 0) begin
        px.fs = 1'b1;
        base = 16'($urandom);
        frame_left = row_len * $urandom_range(2, 5);
        if ($urandom_range(0, 3) == 0) frame_left += $urandom_range(0, row_len - 1);
      end else if (row_len < 256 && $urandom_range(0, 99) == 0) begin
        px.fs = 1'b1;   // restart mid-map
      end
      frame_left--;
      px.color = {pick_channel(), pick_channel(), pick_channel()};
      px.hv = ($urandom_range(0, 9) != 0);
      if ($urandom_range(0, 15) == 0) px.height = 16'($urandom);
      else px.height = 16'(int'(base) + int'($urandom_range(0, 8)) - 4);
      pending_pixels.insert(pending_pixels.size(), px);
    end
  endtask

  initial begin : run_test
    int ph;
    int w;
    int row_len;
    int n;
    bit en;
    for (int i = 0; i < MAX_ROW; i++) begin
      row_above_h[i] = '0;
      row_above_v[i] = 1'b0;
    end
    left_h = '0;
    left_v = 1'b0;
    col_pos = 0;
    in_first_row = 1'b1;
    line_width_reg = LINE_WIDTH_RESET;
    shading_on = 1'b1;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset settings: 4096-pixel rows, so everything stays in the first row.
    queue_terrain(40, MAX_ROW, 1'b1);
    drain();

    // Directed map, 4 pixels per row.
    program_shader(4, 1'b1);
    // first row: extremes, never shaded
    push_px(24'hffffff, -32768, 1'b1, 1'b1);
    push_px(24'h000000,  32767, 1'b1, 1'b0);
    push_px(24'h123456,    100, 1'b1, 1'b0);
    push_px(24'h800000,    100, 1'b1, 1'b0);
    // left edge passes; huge positive offset clamps; huge negative floors at 0
    push_px(24'h808080,      5, 1'b1, 1'b0);
    push_px(24'h10f0e0,  32767, 1'b1, 1'b0);
    push_px(24'hffffff, -32768, 1'b1, 1'b0);
    push_px(24'h7f7f7f,    101, 1'b1, 1'b0);
    // invalid height at the edge, then an invalid left neighbor
    push_px(24'h404040,      0, 1'b0, 1'b0);
    push_px(24'h202020,     10, 1'b1, 1'b0);
    push_px(24'hf0f0f0,     10, 1'b1, 1'b0);
    push_px(24'h0000ff,     11, 1'b1, 1'b0);
    // flat (offset 0), +24, and +48 clamped to 36 with saturation
    push_px(24'h606060,     10, 1'b1, 1'b0);
    push_px(24'h606060,     10, 1'b1, 1'b0);
    push_px(24'h606060,     11, 1'b1, 1'b0);
    push_px(24'h00c0e0,     13, 1'b1, 1'b0);
    // +12, -12 flooring at 0, pixel without a height
    push_px(24'h818181,     13, 1'b1, 1'b0);
    push_px(24'h818181,     12, 1'b1, 1'b0);
    push_px(24'h050505,     11, 1'b1, 1'b0);
    push_px(24'hababab,      0, 1'b0, 1'b0);
    // new map in mid-row
    push_px(24'h111111,     12, 1'b1, 1'b0);
    push_px(24'h222222,     12, 1'b1, 1'b1);
    push_px(24'h333333,     12, 1'b1, 1'b0);
    drain();

    // Widest setting, clamped to the buffer depth: one long first row that
    // fills the line buffer well past every later width, so later width
    // changes never read entries that were never written.
    program_shader(13'h1fff, 1'b1);
    queue_terrain(220, MAX_ROW, 1'b1);
    drain();

    // Shrink in mid-row without a frame start: the current column is past the
    // new width, so that pixel uses its own column and ends the row.
    program_shader(16, 1'b1);
    queue_terrain(120, 16, 1'b0);
    drain();

    // Random settings, including widths 0 and 1 and shading switched off.
    for (ph = 0; ph < 10; ph++) begin
      if (ph == 0) w = 0;
      else if (ph == 1) w = 1;
      else if ($urandom_range(0, 3) == 0) w = $urandom_range(21, 120);
      else w = $urandom_range(2, 20);
      en = (ph % 3 != 2);
      row_len = (w == 0) ? 1 : w;
      n = (row_len > 30) ? 2 * row_len + 10 : 60;
      in_pace = (ph % 4 != 1);
      out_pace = (ph % 4 != 2);
      program_shader(w, en);
      queue_terrain(n, row_len, ($urandom_range(0, 1) == 1));
      drain();
    end

    repeat (8) @(posedge clk);
    if (!run_failed) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: height_map_relief_shader.f
+incdir+design
design/hmrs_pkg.sv
design/hmrs_line_buf.sv
design/hmrs_shade_stage.sv
design/height_map_relief_shader.sv
tb/height_map_relief_shader_test.sv
